### rtl/core/nvcp_pkg.sv
// ----------------------------------------------------------------------------
// nvcp_pkg
// Shared types, character codes, register codes and the power-of-ten table
// of the name=value command parser.
// ----------------------------------------------------------------------------
`default_nettype none

package nvcp_pkg;

	// Dictionary size and fixed field widths
	localparam int NUM_NAMES           = 6;
	localparam int NAME_W              = 64;
	localparam int ADDR_W              = 6;
	localparam int DATA_W              = 64;
	localparam int CNT_W               = 3;
	localparam int VALUE_W             = 57;
	localparam int FRACTION_BITS       = 16;
	localparam int MAX_FRACTION_DIGITS = 12;
	localparam int FD_W                = 4;
	localparam int POW10_W             = 40;

	// Message characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_EQ    = 8'h3D;

	// Register indexes (byte address = 8 * index)
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_NAME_COUNT = 3'd0;
	localparam reg_idx_t REG_NAME_0     = 3'd1;
	localparam reg_idx_t REG_NAME_1     = 3'd2;
	localparam reg_idx_t REG_NAME_2     = 3'd3;
	localparam reg_idx_t REG_NAME_3     = 3'd4;
	localparam reg_idx_t REG_NAME_4     = 3'd5;
	localparam reg_idx_t REG_NAME_5     = 3'd6;

	typedef logic [NUM_NAMES-1:0][NAME_W-1:0] name_tab_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_NAME,
		PH_VSTART,
		PH_VALUE
	} phase_t;

	function automatic logic [POW10_W-1:0] pow10(input logic [FD_W-1:0] fd);
		logic [POW10_W-1:0] p;
		unique case (fd)
			4'd0:    p = 40'd1;
			4'd1:    p = 40'd10;
			4'd2:    p = 40'd100;
			4'd3:    p = 40'd1000;
			4'd4:    p = 40'd10000;
			4'd5:    p = 40'd100000;
			4'd6:    p = 40'd1000000;
			4'd7:    p = 40'd10000000;
			4'd8:    p = 40'd100000000;
			4'd9:    p = 40'd1000000000;
			4'd10:   p = 40'd10000000000;
			4'd11:   p = 40'd100000000000;
			4'd12:   p = 40'd1000000000000;
			default: p = 40'd1;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

### rtl/core/name_value_command_parser_core.sv
// ----------------------------------------------------------------------------
// name_value_command_parser_core
// Byte-serial "name=value#" parser with a six-entry name dictionary and a
// signed Q.16 value result.
// ----------------------------------------------------------------------------
// One item is one message byte. Name bytes are gathered until '=', then the
// dictionary is scanned one entry per cycle (lowest matching entry wins), and
// no byte is taken until the scan ends (count capped at six). Value bytes, a
// leading '-', '.' and ordinary name bytes are taken without a stall. A '#' or
// zero byte ends the message and yields exactly one result item; when the
// value carries fraction digits the result comes from a bit-serial restoring
// divider, one quotient bit per cycle. After a terminator no byte is taken
// until the result is loaded into the output register. A finished result
// waits in the output register while the next message's bytes are already
// taken; only the next terminator waits for it to drain. Dictionary and count
// are written over APB at byte address 8*i and must only change while no
// message is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module name_value_command_parser_core #(
	parameter int NAME_BYTES    = 8,
	parameter int MANTISSA_BITS = 40
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// APB configuration port
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic        [nvcp_pkg::ADDR_W-1:0] paddr,
	input  wire logic        [nvcp_pkg::DATA_W-1:0] pwdata,
	output logic             [nvcp_pkg::DATA_W-1:0] prdata,
	output logic                                    pready,
	// byte input channel
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic        [7:0]                  rx_byte,
	// result channel
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    found,
	output logic             [nvcp_pkg::CNT_W-1:0]  match_index,
	output logic signed      [nvcp_pkg::VALUE_W-1:0] value_q16,
	output logic                                    overflow
);
	import nvcp_pkg::*;

	localparam int NB_W  = 8 * NAME_BYTES;
	localparam int LEN_W = $clog2(NAME_BYTES + 2);
	localparam int ACC_W = MANTISSA_BITS + 1;
	localparam int AW    = MANTISSA_BITS + 6;
	localparam int DW    = MANTISSA_BITS + FRACTION_BITS;
	localparam logic signed [AW-1:0] LIM = AW'((64'd1 << MANTISSA_BITS) - 64'd1);

	// configuration
	logic [CNT_W-1:0] name_count;
	name_tab_t        names;
	logic [CNT_W-1:0] limit;

	// control and parse state
	state_t                  state_q, state_d;
	phase_t                  phase_q;
	logic [NB_W-1:0]         name_buf_q;
	logic [LEN_W-1:0]        name_len_q;
	logic                    hit_q;
	logic [CNT_W-1:0]        hit_idx_q;
	logic [CNT_W-1:0]        scan_q;
	logic                    neg_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    dot_q;
	logic [FD_W-1:0]         fd_q;
	logic                    sat_q;

	// pending result
	logic                    res_found_q;
	logic [CNT_W-1:0]        res_idx_q;
	logic                    res_neg_q;
	logic                    res_sat_q;
	logic [DW-1:0]           res_mag_q;

	// output register
	logic                    out_valid_q;
	logic                    out_found_q;
	logic [CNT_W-1:0]        out_idx_q;
	logic [VALUE_W-1:0]      out_value_q;
	logic                    out_ovf_q;

	// handshake and sequencing
	logic in_fire, is_term, is_eq, is_dot, is_minus;
	logic long_name, scan_ok, entry_hit, match_end;
	logic hit_ok, need_div, out_free, out_load, div_start, div_done;

	// value datapath
	logic signed [AW-1:0]    acc_ext, digit, mac_sum;
	logic signed [ACC_W-1:0] acc_next;
	logic                    mac_sat;
	logic [ACC_W-1:0]        acc_abs;
	logic [DW-1:0]           dividend, div_quo;
	logic [VALUE_W-1:0]      mag_ext;

	nvcp_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.name_count (name_count),
		.names      (names)
	);

	nvcp_div #(
		.DIVIDEND_W (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (pow10(dot_q ? fd_q : FD_W'(0))),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Byte classification
	assign in_fire  = in_valid && !in_stall;
	assign is_term  = (rx_byte == CH_HASH) || (rx_byte == CH_NUL);
	assign is_eq    = (rx_byte == CH_EQ);
	assign is_dot   = (rx_byte == CH_DOT);
	assign is_minus = (rx_byte == CH_MINUS);

	// Dictionary scan: one entry per cycle, stop on the first hit
	assign limit     = (name_count > CNT_W'(NUM_NAMES)) ? CNT_W'(NUM_NAMES) : name_count;
	assign long_name = (name_len_q > LEN_W'(NAME_BYTES));
	assign scan_ok   = !long_name && (scan_q < limit);
	assign entry_hit = scan_ok && (names[scan_q][NB_W-1:0] == name_buf_q);
	assign match_end = !scan_ok || entry_hit;

	// Decimal accumulate: acc*10 + (byte - '0'), clamped to +-(2^M - 1)
	assign acc_ext = AW'(acc_q);
	assign digit   = $signed(AW'(rx_byte)) - $signed(AW'(CH_ZERO));
	assign mac_sum = (acc_ext <<< 3) + (acc_ext <<< 1) + digit;
	always_comb begin
		mac_sat  = 1'b0;
		acc_next = ACC_W'(mac_sum);
		if (mac_sum > LIM) begin
			acc_next = ACC_W'(LIM);
			mac_sat  = 1'b1;
		end else if (mac_sum < -LIM) begin
			acc_next = ACC_W'(-LIM);
			mac_sat  = 1'b1;
		end
	end

	// Magnitude scaled to Q.16; divided only when fraction digits exist
	assign acc_abs  = acc_q[ACC_W-1] ? (~acc_q + ACC_W'(1)) : acc_q;
	assign dividend = {acc_abs[MANTISSA_BITS-1:0], {FRACTION_BITS{1'b0}}};
	assign hit_ok   = (phase_q != PH_NAME) && hit_q;
	assign need_div = hit_ok && dot_q && (fd_q != '0);
	assign out_free = !out_valid_q || !out_stall;

	// Sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (is_term) begin
						state_d = need_div ? ST_DIV : ST_EMIT;
					end else if ((phase_q == PH_NAME) && is_eq) begin
						state_d = ST_MATCH;
					end
				end
			end
			ST_MATCH: begin
				if (match_end) state_d = ST_IDLE;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer: outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE:  div_start = in_fire && is_term && need_div;
			ST_EMIT:  out_load  = out_free;
			ST_MATCH, ST_DIV: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_NAME;
			name_buf_q <= '0;
			name_len_q <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			scan_q     <= '0;
			neg_q      <= 1'b0;
			acc_q      <= '0;
			dot_q      <= 1'b0;
			fd_q       <= '0;
			sat_q      <= 1'b0;
		end else if (in_fire) begin
			if (is_term) begin
				// drop the message and start over in the name phase
				phase_q    <= PH_NAME;
				name_buf_q <= '0;
				name_len_q <= '0;
				hit_q      <= 1'b0;
				hit_idx_q  <= '0;
				scan_q     <= '0;
				neg_q      <= 1'b0;
				acc_q      <= '0;
				dot_q      <= 1'b0;
				fd_q       <= '0;
				sat_q      <= 1'b0;
			end else if (phase_q == PH_NAME) begin
				if (is_eq) begin
					phase_q   <= PH_VSTART;
					scan_q    <= '0;
					hit_q     <= 1'b0;
					hit_idx_q <= '0;
				end else if (name_len_q < LEN_W'(NAME_BYTES)) begin
					for (int k = 0; k < NAME_BYTES; k++) begin
						if (name_len_q == LEN_W'(k)) name_buf_q[8*k +: 8] <= rx_byte;
					end
					name_len_q <= name_len_q + LEN_W'(1);
				end else begin
					name_len_q <= LEN_W'(NAME_BYTES + 1);
				end
			end else begin
				phase_q <= PH_VALUE;
				if ((phase_q == PH_VSTART) && is_minus) begin
					neg_q <= 1'b1;
				end else if (is_dot) begin
					dot_q <= 1'b1;
					fd_q  <= '0;
				end else if (dot_q && (fd_q >= FD_W'(MAX_FRACTION_DIGITS))) begin
					sat_q <= 1'b1;
				end else begin
					if (dot_q) fd_q <= fd_q + FD_W'(1);
					acc_q <= acc_next;
					if (mac_sat) sat_q <= 1'b1;
				end
			end
		end else if (state_q == ST_MATCH) begin
			if (entry_hit) begin
				hit_q     <= 1'b1;
				hit_idx_q <= scan_q;
			end else if (!match_end) begin
				scan_q <= scan_q + CNT_W'(1);
			end
		end
	end

	// Pending result: capture at the terminator, quotient when the divide ends
	always_ff @(posedge clk) begin
		if (in_fire && is_term) begin
			res_found_q <= hit_ok;
			res_idx_q   <= hit_ok ? hit_idx_q : '0;
			res_neg_q   <= hit_ok && (neg_q ^ acc_q[ACC_W-1]);
			res_sat_q   <= hit_ok && sat_q;
			res_mag_q   <= hit_ok ? dividend : '0;
		end else if (div_done) begin
			res_mag_q <= div_quo;
		end
	end

	// Output register: hold until taken
	assign mag_ext = VALUE_W'(res_mag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q <= res_found_q;
			out_idx_q   <= res_idx_q;
			out_value_q <= res_neg_q ? (~mag_ext + VALUE_W'(1)) : mag_ext;
			out_ovf_q   <= res_sat_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = out_found_q;
	assign match_index = out_idx_q;
	assign value_q16   = $signed(out_value_q);
	assign overflow    = out_ovf_q;

endmodule

`default_nettype wire

### rtl/core/nvcp_regs.sv
// ----------------------------------------------------------------------------
// nvcp_regs
// APB register file: entry count and the six dictionary names.
// ----------------------------------------------------------------------------
`default_nettype none

module nvcp_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [nvcp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [nvcp_pkg::DATA_W-1:0] pwdata,
	output logic      [nvcp_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	output logic      [nvcp_pkg::CNT_W-1:0]  name_count,
	output nvcp_pkg::name_tab_t              names
);
	import nvcp_pkg::*;

	reg_idx_t            reg_idx;
	logic                wr_en;
	logic [CNT_W-1:0]    count_q;
	name_tab_t           names_q;

	assign reg_idx = paddr[ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			names_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_NAME_COUNT: count_q    <= pwdata[CNT_W-1:0];
				REG_NAME_0:     names_q[0] <= pwdata;
				REG_NAME_1:     names_q[1] <= pwdata;
				REG_NAME_2:     names_q[2] <= pwdata;
				REG_NAME_3:     names_q[3] <= pwdata;
				REG_NAME_4:     names_q[4] <= pwdata;
				REG_NAME_5:     names_q[5] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_NAME_COUNT: prdata = DATA_W'(count_q);
			REG_NAME_0:     prdata = names_q[0];
			REG_NAME_1:     prdata = names_q[1];
			REG_NAME_2:     prdata = names_q[2];
			REG_NAME_3:     prdata = names_q[3];
			REG_NAME_4:     prdata = names_q[4];
			REG_NAME_5:     prdata = names_q[5];
			default:        prdata = '0;
		endcase
	end

	assign name_count = count_q;
	assign names      = names_q;

endmodule

`default_nettype wire

### rtl/core/nvcp_div.sv
// ----------------------------------------------------------------------------
// nvcp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nvcp_div #(
	parameter int DIVIDEND_W = 56
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [DIVIDEND_W-1:0]        dividend,
	input  wire logic [nvcp_pkg::POW10_W-1:0] divisor,
	output logic                              done,
	output logic      [DIVIDEND_W-1:0]        quotient
);
	import nvcp_pkg::*;

	localparam int CW = $clog2(DIVIDEND_W + 1);

	logic [POW10_W-1:0]    rem_q;
	logic [POW10_W-1:0]    dsr_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [CW-1:0]         cnt_q;
	logic                  done_q;
	logic [POW10_W:0]      shifted;
	logic [POW10_W+1:0]    diff;
	logic                  borrow;

	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
	assign borrow  = diff[POW10_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(DIVIDEND_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CW'(1);
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			// keep the remainder below the divisor
			rem_q <= borrow ? shifted[POW10_W-1:0] : diff[POW10_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ~borrow};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### rtl/core/nvcp_checker.sv
// ----------------------------------------------------------------------------
// nvcp_checker
// Port-level checks on the parser's result and byte channels.
// ----------------------------------------------------------------------------
`default_nettype none

module nvcp_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_stall,
	input wire logic        [7:0]                   rx_byte,
	input wire logic                                out_valid,
	input wire logic                                out_stall,
	input wire logic                                found,
	input wire logic        [nvcp_pkg::CNT_W-1:0]   match_index,
	input wire logic signed [nvcp_pkg::VALUE_W-1:0] value_q16,
	input wire logic                                overflow
);
	import nvcp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) &&
		$stable(match_index) && $stable(value_q16) && $stable(overflow))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (match_index == '0) && (value_q16 == '0) && !overflow)
		else $error("unmatched result carries non-zero fields");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> (match_index < CNT_W'(NUM_NAMES)))
		else $error("match index beyond dictionary");

	a_term_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && ((rx_byte == CH_HASH) || (rx_byte == CH_NUL))
		|=> in_stall)
		else $error("terminator taken without building a result");

endmodule

bind name_value_command_parser_core nvcp_checker u_nvcp_checker (.*);

`default_nettype wire

### tb/sv/tb_name_value_command_parser_core.sv
// ----------------------------------------------------------------------------
// tb_name_value_command_parser_core
// Self-checking bench for the byte-serial name=value command parser.
// ----------------------------------------------------------------------------
// Message bytes are queued by the stimulus process and presented by a clocked
// driver with random gaps. The result side stalls at random. Each accepted
// byte is run through a local model of the parser, which queues the result
// that a terminator should produce. The monitor compares every result with
// the oldest queued one, field by field. The dictionary and entry count are
// reprogrammed over APB between phases, once the parser has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_name_value_command_parser_core;
	timeunit 1ns;
	timeprecision 1ps;

	import nvcp_pkg::*;

	localparam int          NAME_BYTES    = 8;
	localparam int          MANTISSA_BITS = 40;
	localparam logic [63:0] NAME_MASK     = (NAME_BYTES >= 8) ? {64{1'b1}} :
	                                        ((64'd1 << (8 * NAME_BYTES)) - 64'd1);
	localparam longint      ACC_LIMIT     = (longint'(1) << MANTISSA_BITS) - 1;
	// Longest terminator (divider pass) plus margin
	localparam int          SETTLE_CYCLES = 100;
	localparam int          CYCLE_LIMIT   = 600000;
	localparam int          PHASE_BYTES   = 130;

	typedef struct packed {
		logic                      hit;
		logic [CNT_W-1:0]          slot;
		logic signed [VALUE_W-1:0] q16;
		logic                      ovf;
	} parse_result_t;

	// ------------------------------------------------------------------------
	// Clock, reset and block signals
	// ------------------------------------------------------------------------
	logic clk;
	logic arst_n = 1'b0;

	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [ADDR_W-1:0]   paddr   = '0;
	logic [DATA_W-1:0]   pwdata  = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [7:0]          rx_byte   = '0;

	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                found;
	logic [CNT_W-1:0]    match_index;
	logic signed [VALUE_W-1:0] value_q16;
	logic                overflow;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	name_value_command_parser_core #(
		.NAME_BYTES   (NAME_BYTES),
		.MANTISSA_BITS(MANTISSA_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.match_index(match_index),
		.value_q16  (value_q16),
		.overflow   (overflow)
	);

	// ------------------------------------------------------------------------
	// Parser model: configuration mirror and per-message state
	// ------------------------------------------------------------------------
	logic [CNT_W-1:0] dict_count;
	logic [63:0]      dict_entry [NUM_NAMES];

	phase_t      msg_phase;
	logic [63:0] msg_name;
	int unsigned msg_name_len;
	logic        msg_hit;
	logic [2:0]  msg_slot;
	logic        msg_negative;
	longint      msg_acc;
	logic        msg_dot;
	int unsigned msg_frac;
	logic        msg_sat;

	parse_result_t awaited_results[$];
	logic [7:0]    tx_bytes[$];
	int            errors = 0;

	function automatic void clear_message();
		msg_phase    = PH_NAME;
		msg_name     = '0;
		msg_name_len = 0;
		msg_hit      = 1'b0;
		msg_slot     = '0;
		msg_negative = 1'b0;
		msg_acc      = 0;
		msg_dot      = 1'b0;
		msg_frac     = 0;
		msg_sat      = 1'b0;
	endfunction

	// Scan the dictionary in order; the lowest matching entry wins.
	function automatic void lookup_name();
		int unsigned limit;
		limit    = (dict_count > NUM_NAMES) ? NUM_NAMES : dict_count;
		msg_hit  = 1'b0;
		msg_slot = '0;
		if (msg_name_len > NAME_BYTES)
			return;
		for (int i = 0; i < limit; i++) begin
			if ((dict_entry[i] & NAME_MASK) == msg_name) begin
				msg_hit  = 1'b1;
				msg_slot = 3'(i);
				return;
			end
		end
	endfunction

	// Fold one value byte into the decimal accumulator. Any byte but '.'
	// counts as a digit, even when it lies outside '0'..'9'.
	function automatic void fold_value_byte(logic [7:0] b);
		longint nxt;
		if (b == CH_DOT) begin
			msg_dot  = 1'b1;
			msg_frac = 0;
			return;
		end
		if (msg_dot) begin
			// drop digits beyond the fraction limit
			if (msg_frac >= MAX_FRACTION_DIGITS) begin
				msg_sat = 1'b1;
				return;
			end
			msg_frac++;
		end
		nxt = msg_acc * 10 + longint'(b) - longint'(CH_ZERO);
		if (nxt > ACC_LIMIT) begin
			nxt     = ACC_LIMIT;
			msg_sat = 1'b1;
		end else if (nxt < -ACC_LIMIT) begin
			nxt     = -ACC_LIMIT;
			msg_sat = 1'b1;
		end
		msg_acc = nxt;
	endfunction

	// Accumulator over 10^digits in Q.16, truncated toward zero.
	function automatic logic signed [VALUE_W-1:0] scaled_value();
		logic [63:0] mag;
		logic [63:0] divisor;
		logic        negate;
		int unsigned digits;
		negate = msg_negative;
		if (msg_acc < 0) begin
			negate = !negate;
			mag    = -msg_acc;
		end else begin
			mag = msg_acc;
		end
		digits = msg_dot ? msg_frac : 0;
		if (digits > MAX_FRACTION_DIGITS)
			digits = MAX_FRACTION_DIGITS;
		divisor = 64'd1;
		repeat (digits) divisor = divisor * 64'd10;
		mag = (mag << FRACTION_BITS) / divisor;
		if (negate)
			mag = -mag;
		return mag[VALUE_W-1:0];
	endfunction

	// Advance the model by one accepted byte; a terminator queues a result.
	function automatic void parse_byte(logic [7:0] b);
		parse_result_t r;
		if (b == CH_HASH || b == CH_NUL) begin
			r = '0;
			if (msg_phase != PH_NAME && msg_hit) begin
				r.hit  = 1'b1;
				r.slot = msg_slot;
				r.q16  = scaled_value();
				r.ovf  = msg_sat;
			end
			awaited_results.push_back(r);
			clear_message();
		end else if (msg_phase == PH_NAME) begin
			if (b == CH_EQ) begin
				lookup_name();
				msg_phase = PH_VSTART;
			end else if (msg_name_len < NAME_BYTES) begin
				msg_name = msg_name | (64'(b) << (8 * msg_name_len));
				msg_name_len++;
			end else begin
				// too long: can never match
				msg_name_len = NAME_BYTES + 1;
			end
		end else if (msg_phase == PH_VSTART) begin
			msg_phase = PH_VALUE;
			if (b == CH_MINUS)
				msg_negative = 1'b1;
			else
				fold_value_byte(b);
		end else begin
			fold_value_byte(b);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Idling: mode 0 never waits, 1 waits now and then, 2 waits often
	// ------------------------------------------------------------------------
	function automatic int draw_wait(int mode);
		if (mode == 0)
			return 0;
		if (mode == 1)
			return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
		return $urandom_range(0, 16);
	endfunction

	// ------------------------------------------------------------------------
	// Byte driver: present queued bytes at the falling edge, hold while stalled
	// ------------------------------------------------------------------------
	logic byte_fire = 1'b0;
	int   tx_gap      = 0;
	int   tx_mode     = 0;
	int   tx_mode_cnt = 0;

	always @(posedge clk) begin
		byte_fire <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			parse_byte(rx_byte);
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || byte_fire) begin
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (tx_bytes.size() > 0) begin
				rx_byte  <= tx_bytes.pop_front();
				in_valid <= 1'b1;
				// change the idling pattern every few dozen items
				if (tx_mode_cnt == 0) begin
					tx_mode     = $urandom_range(0, 2);
					tx_mode_cnt = 24;
				end
				tx_mode_cnt--;
				tx_gap = draw_wait(tx_mode);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor and stall generator
	// ------------------------------------------------------------------------
	logic result_fire = 1'b0;
	int   rx_stall      = 0;
	int   rx_mode       = 0;
	int   rx_mode_cnt   = 0;

	always @(posedge clk) begin
		parse_result_t want;
		result_fire <= arst_n && out_valid && !out_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result: found=%0d index=%0d value=%0d ovf=%0d",
					$time, found, match_index, value_q16, overflow);
				errors++;
			end else begin
				want = awaited_results.pop_front();
				if (found !== want.hit) begin
					$display("%0t: found mismatch: expected %0d, got %0d",
						$time, want.hit, found);
					errors++;
				end
				if (match_index !== want.slot) begin
					$display("%0t: match_index mismatch: expected %0d, got %0d",
						$time, want.slot, match_index);
					errors++;
				end
				if (value_q16 !== want.q16) begin
					$display("%0t: value_q16 mismatch: expected %0d, got %0d",
						$time, want.q16, value_q16);
					errors++;
				end
				if (overflow !== want.ovf) begin
					$display("%0t: overflow mismatch: expected %0d, got %0d",
						$time, want.ovf, overflow);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		// draw a fresh stall length after each result
		if (result_fire) begin
			if (rx_mode_cnt == 0) begin
				rx_mode     = $urandom_range(0, 2);
				rx_mode_cnt = 8;
			end
			rx_mode_cnt--;
			rx_stall = draw_wait(rx_mode);
		end
		if (rx_stall > 0) begin
			rx_stall--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------------
	int cycles = 0;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("name_value_command_parser_core test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic write_reg(reg_idx_t idx, logic [63:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(8 * idx);
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_NAME_COUNT)
			dict_count = data[CNT_W-1:0];
		else
			dict_entry[idx - REG_NAME_0] = data;
	endtask

	function automatic logic [63:0] pack_name(string s);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < s.len() && i < 8; i++)
			v = v | (64'(s[i]) << (8 * i));
		return v;
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			tx_bytes.push_back(s[i]);
	endfunction

	// Any byte that may sit inside a name: not a terminator, not '='.
	function automatic logic [7:0] name_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255)); while (b == CH_HASH || b == CH_EQ);
		return b;
	endfunction

	function automatic logic [7:0] digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// Mostly dictionary names with random values; some stray names, broken
	// messages and raw noise.
	function automatic void push_random_message();
		int          kind;
		int          form;
		int          n;
		int          dot_at;
		logic [63:0] e;
		logic [7:0]  b;
		kind = $urandom_range(0, 99);
		if (kind < 75) begin
			e = dict_entry[$urandom_range(0, NUM_NAMES - 1)];
			for (int i = 0; i < 8 && e[8*i +: 8] != 8'h00; i++)
				tx_bytes.push_back(e[8*i +: 8]);
		end else if (kind < 88) begin
			n = $urandom_range(0, 11);
			repeat (n) tx_bytes.push_back(name_byte());
		end else begin
			// raw noise, terminators included
			n = $urandom_range(1, 8);
			repeat (n) tx_bytes.push_back(8'($urandom_range(0, 255)));
			tx_bytes.push_back(CH_HASH);
			return;
		end
		if ($urandom_range(0, 15) != 0)
			tx_bytes.push_back(CH_EQ);
		if ($urandom_range(0, 2) == 0)
			tx_bytes.push_back(CH_MINUS);
		form = $urandom_range(0, 9);
		if (form == 0) begin
			// 12 to 18 digits, which may saturate the accumulator
			n = $urandom_range(12, 18);
			repeat (n) tx_bytes.push_back(digit());
		end else if (form == 1) begin
			// fraction of 11 to 15 digits, around the digit limit
			if ($urandom_range(0, 1) == 0)
				tx_bytes.push_back(digit());
			tx_bytes.push_back(CH_DOT);
			n = $urandom_range(11, 15);
			repeat (n) tx_bytes.push_back(digit());
		end else if (form == 2) begin
			n = $urandom_range(1, 6);
			repeat (n) begin
				do b = 8'($urandom_range(1, 255)); while (b == CH_HASH);
				tx_bytes.push_back(b);
			end
		end else begin
			n      = $urandom_range(0, 8);
			dot_at = $urandom_range(0, n + 2);
			for (int i = 0; i < n; i++) begin
				if (i == dot_at)
					tx_bytes.push_back(CH_DOT);
				tx_bytes.push_back(digit());
			end
			if (dot_at == n)
				tx_bytes.push_back(CH_DOT);
		end
		tx_bytes.push_back(($urandom_range(0, 7) == 0) ? CH_NUL : CH_HASH);
	endfunction

	// Wait until every byte is taken and every result checked, then allow
	// the divider time to finish anything still in flight.
	task automatic wait_drained();
		while (tx_bytes.size() != 0 || in_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int          counts[5];
		int          pick;
		logic [63:0] entry;

		dict_count = '0;
		foreach (dict_entry[i])
			dict_entry[i] = '0;
		clear_message();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed dictionary: count above the table size, a duplicate entry,
		// an empty entry and an all-ones entry.
		write_reg(REG_NAME_COUNT, 64'd7);
		write_reg(REG_NAME_0, pack_name("k"));
		write_reg(REG_NAME_1, 64'd0);
		write_reg(REG_NAME_2, pack_name("speedmax"));
		write_reg(REG_NAME_3, pack_name("k"));
		write_reg(REG_NAME_4, {64{1'b1}});
		write_reg(REG_NAME_5, pack_name("v"));

		push_text("k=1.5#");
		// empty name, negative sign, zero-byte terminator
		push_text("=-7");
		tx_bytes.push_back(CH_NUL);
		// terminator before '='
		push_text("a#");
		// full-length name, accumulator saturates
		push_text("speedmax=9999999999999#");
		// too many fraction digits
		push_text("k=-.0000000000001#");
		// one byte too long to match
		push_text("speedmaxx=1#");
		// unknown name
		push_text("q=5#");
		// non-digit bytes in the value, several dots; last entry reachable
		push_text("v=1-=.2.3#");
		push_text("#");
		// name of all-ones bytes
		repeat (8) tx_bytes.push_back(8'hFF);
		push_text("=3#");
		wait_drained();

		// Random phases, each with a fresh dictionary
		counts = '{6, 0, 7, 1, $urandom_range(0, 7)};
		foreach (counts[p]) begin
			write_reg(REG_NAME_COUNT, 64'(counts[p]));
			for (int i = 0; i < NUM_NAMES; i++) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					entry = '0;
				end else if (pick == 1) begin
					entry = {$urandom, $urandom};
				end else if (pick == 2 && i > 0) begin
					entry = dict_entry[$urandom_range(0, i - 1)];
				end else begin
					entry = '0;
					for (int k = 0; k < $urandom_range(1, 8); k++)
						entry[8*k +: 8] = name_byte();
				end
				write_reg(reg_idx_t'(REG_NAME_0 + i), entry);
			end
			while (tx_bytes.size() < PHASE_BYTES)
				push_random_message();
			wait_drained();
		end

		if (errors == 0)
			$display("name_value_command_parser_core test passed");
		else
			$display("name_value_command_parser_core test failed");
		$finish;
	end

endmodule

`default_nettype wire

### name_value_command_parser_core.f
rtl/core/nvcp_pkg.sv
rtl/core/nvcp_regs.sv
rtl/core/nvcp_div.sv
rtl/core/name_value_command_parser_core.sv
rtl/core/nvcp_checker.sv
tb/sv/tb_name_value_command_parser_core.sv
